[rtl/bffa_pkg.sv]
`timescale 1ns / 1ps
package bffa_pkg;

  // Fixed widths of the item fields.
  localparam int OP_W   = 2;
  localparam int IDX_W  = 12;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 13;

  // The full-word search runs over groups of this many words.
  localparam int GRP_BITS  = 32;
  localparam int GRP_IDX_W = 5;

  localparam logic [OP_W-1:0] OP_FIND      = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK_USED = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_BIT,
    S_ADDR,
    S_UPDATE
  } state_t;

endpackage

[rtl/bffa_ram.sv]
`timescale 1ns / 1ps
module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bitmap_first_free_allocator_core.sv]
`timescale 1ns / 1ps
// First-fit allocator over two occupancy bitmaps: data blocks (pool 0) and
// inodes (pool 1). A set bit means the entry is used.
//
// Input channel: start, in_operation, in_pool, in_index. An item is taken
// on a clock edge where start is high and busy is low. Result channel:
// out_valid marks out_status, out_found_index and out_free_count for exactly
// one cycle; the receiver must take it then, it cannot stall the block.
//
// Steps from the accept edge to the edge that latches the result: a find
// runs group summary, group pick plus memory read, then bit encode; a find on
// a full pool ends with the group pick; a mark runs word address plus read,
// then write back; an out-of-range mark or the unused operation code ends with
// the word address step. busy falls in the cycle the result is shown, so the
// next item may start then; no new item is taken while one is in work. A mark
// is a read-modify-write on bitmap memories with a single write port.
// After reset the block sweeps both bitmap memories to zero, one word per
// cycle, over max(BLOCK_WORDS, INODE_WORDS) word addresses with busy held
// high. The per-word full flags and the free counters are set at once by reset.
module bitmap_first_free_allocator_core #(
  parameter int BLOCK_WORDS = 128,
  parameter int INODE_WORDS = 32,
  parameter int WORD_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bffa_pkg::OP_W-1:0]     in_operation,
  input  logic                          in_pool,
  input  logic [bffa_pkg::IDX_W-1:0]    in_index,
  output logic                          out_valid,
  output logic [bffa_pkg::STAT_W-1:0]   out_status,
  output logic [bffa_pkg::IDX_W-1:0]    out_found_index,
  output logic [bffa_pkg::CNT_W-1:0]    out_free_count
);
  import bffa_pkg::*;

  localparam int MAX_WORDS  = (BLOCK_WORDS > INODE_WORDS) ? BLOCK_WORDS : INODE_WORDS;
  localparam int BAW        = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int IAW        = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
  localparam int MAW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int BLOCK_SIZE = BLOCK_WORDS * WORD_BITS;
  localparam int INODE_SIZE = INODE_WORDS * WORD_BITS;
  localparam int BCNT_W     = $clog2(BLOCK_SIZE + 1);
  localparam int ICNT_W     = $clog2(INODE_SIZE + 1);
  localparam int NGRP       = (MAX_WORDS + GRP_BITS - 1) / GRP_BITS;
  localparam int NG_W       = (NGRP > 1) ? $clog2(NGRP) : 1;
  // Word number by reciprocal multiplication, exact for every 12-bit index.
  localparam int SH         = IDX_W + $clog2(WORD_BITS);
  localparam int RECIP      = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W    = SH + 1;
  localparam int PROD_W     = IDX_W + RECIP_W;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]    op_r;
  logic               pool_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   q_r;
  logic [IDX_W-1:0]   word_r;
  logic [BIT_W-1:0]   bit_r;
  logic [MAW-1:0]     clr_addr_r;
  logic               clr_done;

  logic [BLOCK_WORDS-1:0] block_full_r;
  logic [INODE_WORDS-1:0] inode_full_r;
  logic [BCNT_W-1:0]      bcnt_r, bcnt_nxt;
  logic [ICNT_W-1:0]      icnt_r, icnt_nxt;

  logic [NGRP-1:0]          grp_any_r, grp_any;
  logic [GRP_IDX_W-1:0]     grp_first_r [NGRP];
  logic [GRP_IDX_W-1:0]     grp_first   [NGRP];
  logic [NGRP*GRP_BITS-1:0] avail;
  logic [NG_W-1:0]          pick_g;
  logic                     pick_any;
  logic [IDX_W-1:0]         pick_word;

  logic [PROD_W-1:0] in_prod;
  logic [IDX_W-1:0]  in_q;
  logic [IDX_W-1:0]  rem_full;
  logic              in_range;
  logic              is_mark;

  logic [IDX_W-1:0]     rd_word;
  logic [WORD_BITS-1:0] block_rdata, inode_rdata, rd_data;
  logic [WORD_BITS-1:0] bit_mask, new_word;
  logic                 was_used;
  logic [BIT_W-1:0]     free_bit;

  logic                 block_we, inode_we;
  logic [BAW-1:0]       block_waddr;
  logic [IAW-1:0]       inode_waddr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 bfull_we, ifull_we;

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_found_r, out_found_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_free_count  = out_count_r;

  assign clr_done = (clr_addr_r == MAW'(MAX_WORDS - 1));

  // Word number of the incoming index, and the bit within the word.
  assign in_prod  = PROD_W'(in_index) * PROD_W'(RECIP);
  assign in_q     = in_prod[SH +: IDX_W];
  assign rem_full = idx_r - IDX_W'(q_r * IDX_W'(WORD_BITS));
  assign in_range = (32'(idx_r) < (pool_r ? 32'(INODE_SIZE) : 32'(BLOCK_SIZE)));
  assign is_mark  = (op_r == OP_MARK_USED) || (op_r == OP_MARK_FREE);

  // First level of the search: lowest non-full word inside each group.
  always_comb begin
    avail = '0;
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      avail[i] = ~pool_r & ~block_full_r[i];
    end
    for (int i = 0; i < INODE_WORDS; i++) begin
      if (pool_r) begin
        avail[i] = ~inode_full_r[i];
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g]   = |avail[g*GRP_BITS +: GRP_BITS];
      grp_first[g] = '0;
      for (int b = GRP_BITS - 1; b >= 0; b--) begin
        if (avail[g*GRP_BITS + b]) begin
          grp_first[g] = GRP_IDX_W'(b);
        end
      end
    end
  end

  // Second level: lowest group that has a non-full word.
  always_comb begin
    pick_g   = '0;
    pick_any = |grp_any_r;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        pick_g = NG_W'(g);
      end
    end
    pick_word = (IDX_W'(pick_g) << GRP_IDX_W) | IDX_W'(grp_first_r[pick_g]);
  end

  assign rd_word = (state_r == S_PICK) ? pick_word : q_r;
  assign rd_data = pool_r ? inode_rdata : block_rdata;

  always_comb begin
    free_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!rd_data[b]) begin
        free_bit = BIT_W'(b);
      end
    end
  end

  assign bit_mask = WORD_BITS'(1) << bit_r;
  assign was_used = |(rd_data & bit_mask);
  assign new_word = (op_r == OP_MARK_USED) ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_operation == OP_FIND) ? S_SCAN : S_ADDR;
        end
      end
      S_SCAN:   state_nxt = S_PICK;
      S_PICK:   state_nxt = pick_any ? S_BIT : S_IDLE;
      S_BIT:    state_nxt = S_IDLE;
      S_ADDR:   state_nxt = (is_mark && in_range) ? S_UPDATE : S_IDLE;
      S_UPDATE: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Memory writes, counters and the result.
  always_comb begin
    block_we       = 1'b0;
    inode_we       = 1'b0;
    bfull_we       = 1'b0;
    ifull_we       = 1'b0;
    wr_data        = new_word;
    block_waddr    = BAW'(word_r);
    inode_waddr    = IAW'(word_r);
    bcnt_nxt       = bcnt_r;
    icnt_nxt       = icnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_found_nxt  = idx_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_data     = '0;
        block_waddr = BAW'(clr_addr_r);
        inode_waddr = IAW'(clr_addr_r);
        block_we    = (32'(clr_addr_r) < 32'(BLOCK_WORDS));
        inode_we    = (32'(clr_addr_r) < 32'(INODE_WORDS));
      end
      S_PICK: begin
        if (!pick_any) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_FULL;
          out_found_nxt  = '0;
        end
      end
      S_BIT: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = IDX_W'(word_r * IDX_W'(WORD_BITS)) + IDX_W'(free_bit);
      end
      S_ADDR: begin
        if (!is_mark) begin
          out_valid_nxt = 1'b1;
        end else if (!in_range) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_RANGE;
        end
      end
      S_UPDATE: begin
        out_valid_nxt = 1'b1;
        block_we      = ~pool_r;
        inode_we      = pool_r;
        bfull_we      = ~pool_r;
        ifull_we      = pool_r;
        // The counter moves only when the bit really flips.
        if (op_r == OP_MARK_USED && !was_used) begin
          if (!pool_r && bcnt_r != '0) begin
            bcnt_nxt = bcnt_r - 1'b1;
          end
          if (pool_r && icnt_r != '0) begin
            icnt_nxt = icnt_r - 1'b1;
          end
        end else if (op_r == OP_MARK_FREE && was_used) begin
          if (!pool_r && 32'(bcnt_r) < 32'(BLOCK_SIZE)) begin
            bcnt_nxt = bcnt_r + 1'b1;
          end
          if (pool_r && 32'(icnt_r) < 32'(INODE_SIZE)) begin
            icnt_nxt = icnt_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    out_count_nxt = pool_r ? CNT_W'(icnt_nxt) : CNT_W'(bcnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
      block_full_r <= '0;
      inode_full_r <= '0;
      bcnt_r       <= BCNT_W'(BLOCK_SIZE);
      icnt_r       <= ICNT_W'(INODE_SIZE);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bcnt_r      <= bcnt_nxt;
      icnt_r      <= icnt_nxt;
      if (state_r == S_CLEAR && !clr_done) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (bfull_we) begin
        block_full_r[BAW'(word_r)] <= &new_word;
      end
      if (ifull_we) begin
        inode_full_r[IAW'(word_r)] <= &new_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    if (state_r == S_IDLE && start) begin
      op_r   <= in_operation;
      pool_r <= in_pool;
      idx_r  <= in_index;
      q_r    <= in_q;
    end
    if (state_r == S_SCAN) begin
      grp_any_r   <= grp_any;
      grp_first_r <= grp_first;
    end
    if (state_r == S_PICK || state_r == S_ADDR) begin
      word_r <= rd_word;
    end
    if (state_r == S_ADDR) begin
      bit_r <= rem_full[BIT_W-1:0];
    end
  end

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BLOCK_WORDS)
  ) u_block_ram (
    .clk   (clk),
    .we    (block_we),
    .waddr (block_waddr),
    .wdata (wr_data),
    .raddr (BAW'(rd_word)),
    .rdata (block_rdata)
  );

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (INODE_WORDS)
  ) u_inode_ram (
    .clk   (clk),
    .we    (inode_we),
    .waddr (inode_waddr),
    .wdata (wr_data),
    .raddr (IAW'(rd_word)),
    .rdata (inode_rdata)
  );

endmodule

[rtl/bffa_checker.sv]
`timescale 1ns / 1ps
module bffa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [bffa_pkg::OP_W-1:0]     in_operation,
  input logic                          in_pool,
  input logic [bffa_pkg::IDX_W-1:0]    in_index,
  input logic                          out_valid,
  input logic [bffa_pkg::STAT_W-1:0]   out_status,
  input logic [bffa_pkg::IDX_W-1:0]    out_found_index,
  input logic [bffa_pkg::CNT_W-1:0]    out_free_count
);
  import bffa_pkg::*;

  // An accepted item keeps the block busy until its result is out.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result closes the work on its item, so the block is free again.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // No result appears without an item having been worked on.
  a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // A full pool has nothing free and reports entry zero.
  a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_found_index == '0 && out_free_count == '0)
    else $error("full status with nonzero index or free count");

endmodule

bind bitmap_first_free_allocator_core bffa_checker u_bffa_checker (.*);
